### hdl/opnc_pkg.sv
// ----------------------------------------------------------------------------
// opnc_pkg
// Types, codes and fixed-point helpers for the orthogonal polynomial
// nonlinearity correction.
// ----------------------------------------------------------------------------
`default_nettype none

package opnc_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int RESULT_WIDTH    = 40;
  localparam int FRAC_BITS       = 24;
  localparam int WIDE_WIDTH      = 64;
  localparam int CHANNEL_WIDTH   = 16;
  localparam int INDEX_WIDTH     = 4;
  localparam int TERMS_WIDTH     = 4;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int IN_TDATA_WIDTH  = 120;
  localparam int OUT_TDATA_WIDTH = 40;

  // s_tdata field positions
  localparam int IDX_LSB   = 0;
  localparam int ALPHA_LSB = IDX_LSB + INDEX_WIDTH;
  localparam int BETA_LSB  = ALPHA_LSB + VALUE_WIDTH;
  localparam int WGT_LSB   = BETA_LSB + VALUE_WIDTH;
  localparam int CHAN_LSB  = WGT_LSB + VALUE_WIDTH;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ENABLE      = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_X_OFFSET    = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_X_SCALE     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BASE_OFFSET = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BASE_SLOPE  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NUM_TERMS   = 3'd5;

  localparam logic signed [WIDE_WIDTH-1:0] V_MAX =
    (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [WIDE_WIDTH-1:0] V_MIN = -V_MAX - 64'sd1;
  localparam logic signed [WIDE_WIDTH-1:0] R_MAX =
    (64'sd1 <<< (RESULT_WIDTH - 1)) - 64'sd1;
  localparam logic signed [WIDE_WIDTH-1:0] R_MIN = -R_MAX - 64'sd1;
  localparam logic signed [WIDE_WIDTH-1:0] HALF  = 64'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XMUL,
    ST_XADD,
    ST_BMUL,
    ST_BADD,
    ST_D,
    ST_M1,
    ST_P,
    ST_W,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] alpha;
    logic signed [VALUE_WIDTH-1:0] beta;
    logic signed [VALUE_WIDTH-1:0] weight;
  } coef_t;

  typedef struct packed {
    logic                          ovf;
    logic signed [VALUE_WIDTH-1:0] val;
  } vclip_t;

  typedef struct packed {
    logic                           ovf;
    logic signed [RESULT_WIDTH-1:0] val;
  } rclip_t;

  function automatic vclip_t clip_v(input logic signed [WIDE_WIDTH-1:0] v);
    vclip_t r;
    if (v > V_MAX) begin
      r.ovf = 1'b1;
      r.val = V_MAX[VALUE_WIDTH-1:0];
    end else if (v < V_MIN) begin
      r.ovf = 1'b1;
      r.val = V_MIN[VALUE_WIDTH-1:0];
    end else begin
      r.ovf = 1'b0;
      r.val = v[VALUE_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic rclip_t clip_r(input logic signed [WIDE_WIDTH-1:0] v);
    rclip_t r;
    if (v > R_MAX) begin
      r.ovf = 1'b1;
      r.val = R_MAX[RESULT_WIDTH-1:0];
    end else if (v < R_MIN) begin
      r.ovf = 1'b1;
      r.val = R_MIN[RESULT_WIDTH-1:0];
    end else begin
      r.ovf = 1'b0;
      r.val = v[RESULT_WIDTH-1:0];
    end
    return r;
  endfunction

  // Q.24 product to Q.24, rounded half away from zero
  function automatic logic signed [WIDE_WIDTH-1:0] qround(
    input logic signed [WIDE_WIDTH-1:0] p
  );
    logic signed [WIDE_WIDTH-1:0] t;
    if (p[WIDE_WIDTH-1]) begin
      t = p + (HALF - 64'sd1);
    end else begin
      t = p + HALF;
    end
    return t >>> FRAC_BITS;
  endfunction

endpackage

`default_nettype wire

### hdl/orthopoly_nonlinearity_correct.sv
// ----------------------------------------------------------------------------
// orthopoly_nonlinearity_correct
// ADC nonlinearity correction: linear baseline plus a sum of weighted
// orthogonal polynomials built by the three-term recurrence. Coefficients
// live in one RAM; one shared 32x32 multiplier does all products.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid/s_tready    tuser cmd; tdata index, coefs, channel
//  m_*       out   m_tvalid/m_tready    tuser saturated; tdata correction
//  cfg_*     in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Table write: done in ST_IDLE. Evaluate, disabled: straight to ST_OUT.
//  Enabled: ST_XMUL..ST_BADD, per term ST_D/M1/P/W (three multiplier passes),
//  ST_ACC if terms > 0, ST_OUT; terms is num_terms capped at TABLE_DEPTH-1.
//  One beat is processed at a time; s_tready is low while evaluating or
//  while a finished result waits for room in the output register.
//  Reset clears configuration and control; the table is undefined until
//  written. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module orthopoly_nonlinearity_correct #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // [3:0] entry_index, [35:4] alpha_value, [67:36] beta_value,
  // [99:68] weight_value, [115:100] channel, [119:116] zero
  input  wire logic [opnc_pkg::IN_TDATA_WIDTH-1:0]    s_tdata,
  // [0] cmd
  input  wire logic                                   s_tuser,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // [39:0] correction
  output logic [opnc_pkg::OUT_TDATA_WIDTH-1:0]        m_tdata,
  // [0] saturated
  output logic                                        m_tuser,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [opnc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [opnc_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

  import opnc_pkg::*;

  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int TERM_CAP = TABLE_DEPTH - 1;

  // configuration
  logic                          enable;
  logic signed [VALUE_WIDTH-1:0] x_offset;
  logic signed [VALUE_WIDTH-1:0] x_scale;
  logic signed [VALUE_WIDTH-1:0] base_offset;
  logic signed [VALUE_WIDTH-1:0] base_slope;
  logic [TERMS_WIDTH-1:0]        num_terms;

  state_t state, state_next;

  logic [AW-1:0]                  rd_addr, rd_addr_next;
  coef_t                          rd_word;
  coef_t                          wr_word;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;

  logic [CHANNEL_WIDTH:0]         ch1;
  logic [TERMS_WIDTH-1:0]         terms;
  logic [TERMS_WIDTH-1:0]         terms_eff;
  logic [TERMS_WIDTH-1:0]         k;
  logic signed [VALUE_WIDTH-1:0]  x;
  logic signed [VALUE_WIDTH-1:0]  p_prev;
  logic signed [VALUE_WIDTH-1:0]  p_cur;
  logic signed [VALUE_WIDTH-1:0]  d;
  logic signed [VALUE_WIDTH-1:0]  t2;
  logic signed [VALUE_WIDTH-1:0]  beta_r;
  logic signed [VALUE_WIDTH-1:0]  weight_r;
  logic signed [RESULT_WIDTH-1:0] acc;
  logic                           sat;
  logic signed [WIDE_WIDTH-1:0]   prod;

  logic signed [VALUE_WIDTH-1:0]  mul_a, mul_b;
  logic signed [WIDE_WIDTH-1:0]   q;
  vclip_t                         q_v, x_c, a_c, pn_c;
  rclip_t                         q_r, base_c, acc_c;

  logic in_beat, out_room;

  assign cfg_ready = 1'b1;
  assign in_beat   = s_tvalid && s_tready;
  assign out_room  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      x_offset    <= '0;
      x_scale     <= '0;
      base_offset <= '0;
      base_slope  <= '0;
      num_terms   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE:      enable      <= cfg_data[0];
        CFG_X_OFFSET:    x_offset    <= cfg_data[VALUE_WIDTH-1:0];
        CFG_X_SCALE:     x_scale     <= cfg_data[VALUE_WIDTH-1:0];
        CFG_BASE_OFFSET: base_offset <= cfg_data[VALUE_WIDTH-1:0];
        CFG_BASE_SLOPE:  base_slope  <= cfg_data[VALUE_WIDTH-1:0];
        CFG_NUM_TERMS:   num_terms   <= cfg_data[TERMS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // coefficient table
  assign wr_word.alpha  = s_tdata[ALPHA_LSB +: VALUE_WIDTH];
  assign wr_word.beta   = s_tdata[BETA_LSB +: VALUE_WIDTH];
  assign wr_word.weight = s_tdata[WGT_LSB +: VALUE_WIDTH];
  assign wr_addr        = AW'(s_tdata[IDX_LSB +: INDEX_WIDTH]);
  assign wr_en          = in_beat && (s_tuser == CMD_WRITE) &&
                          (int'(s_tdata[IDX_LSB +: INDEX_WIDTH]) < TABLE_DEPTH);

  opnc_ram #(
    .WIDTH($bits(coef_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_word),
    .raddr (rd_addr_next),
    .rdata (rd_word)
  );

  assign terms_eff = (int'(num_terms) > TERM_CAP) ? TERMS_WIDTH'(TERM_CAP) : num_terms;

  // shared arithmetic
  assign q      = qround(prod);
  assign q_v    = clip_v(q);
  assign q_r    = clip_r(q);
  assign x_c    = clip_v(WIDE_WIDTH'(x_offset) + prod);
  assign a_c    = clip_v(WIDE_WIDTH'(x) - WIDE_WIDTH'(rd_word.alpha));
  assign pn_c   = clip_v(WIDE_WIDTH'(q_v.val) - WIDE_WIDTH'(t2));
  assign base_c = clip_r(WIDE_WIDTH'(q_r.val) + WIDE_WIDTH'(base_offset));
  assign acc_c  = clip_r(WIDE_WIDTH'(acc) + WIDE_WIDTH'(q_r.val));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_addr <= '0;
    end else begin
      state   <= state_next;
      rd_addr <= rd_addr_next;
    end
  end

  always_comb begin
    state_next   = state;
    rd_addr_next = rd_addr;
    s_tready     = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && (s_tuser == CMD_EVAL)) begin
          rd_addr_next = '0;
          state_next   = enable ? ST_XMUL : ST_OUT;
        end
      end
      ST_XMUL: begin
        mul_a      = VALUE_WIDTH'(ch1);
        mul_b      = x_scale;
        state_next = ST_XADD;
      end
      ST_XADD: state_next = ST_BMUL;
      ST_BMUL: begin
        mul_a      = base_slope;
        mul_b      = x;
        state_next = ST_BADD;
      end
      ST_BADD: begin
        if (terms == '0) begin
          state_next = ST_OUT;
        end else begin
          rd_addr_next = AW'(1);
          state_next   = ST_D;
        end
      end
      ST_D: begin
        mul_a      = beta_r;
        mul_b      = p_prev;
        state_next = ST_M1;
      end
      ST_M1: begin
        mul_a      = d;
        mul_b      = p_cur;
        state_next = ST_P;
      end
      ST_P: state_next = ST_W;
      ST_W: begin
        mul_a        = weight_r;
        mul_b        = p_cur;
        rd_addr_next = rd_addr + AW'(1);
        state_next   = (k == terms - TERMS_WIDTH'(1)) ? ST_ACC : ST_D;
      end
      ST_ACC: state_next = ST_OUT;
      ST_OUT: begin
        if (out_room) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        ch1   <= {1'b0, s_tdata[CHAN_LSB +: CHANNEL_WIDTH]} + (CHANNEL_WIDTH + 1)'(1);
        terms <= terms_eff;
        k     <= '0;
        acc   <= '0;
        sat   <= 1'b0;
      end
      ST_XADD: begin
        x   <= x_c.val;
        sat <= sat | x_c.ovf;
      end
      ST_BMUL: begin
        p_prev   <= V_MAX[VALUE_WIDTH-1:0] & VALUE_WIDTH'(64'sd1 <<< FRAC_BITS);
        p_cur    <= a_c.val;
        beta_r   <= rd_word.beta;
        weight_r <= rd_word.weight;
        sat      <= sat | a_c.ovf;
      end
      ST_BADD: begin
        acc <= base_c.val;
        sat <= sat | q_r.ovf | base_c.ovf;
      end
      ST_D: begin
        d <= a_c.val;
        if (k != '0) begin
          acc <= acc_c.val;
          sat <= sat | a_c.ovf | q_r.ovf | acc_c.ovf;
        end else begin
          sat <= sat | a_c.ovf;
        end
      end
      ST_M1: begin
        t2  <= q_v.val;
        sat <= sat | q_v.ovf;
      end
      ST_P: begin
        p_prev <= p_cur;
        p_cur  <= pn_c.val;
        sat    <= sat | q_v.ovf | pn_c.ovf;
      end
      ST_W: begin
        beta_r   <= rd_word.beta;
        weight_r <= rd_word.weight;
        if (k != terms - TERMS_WIDTH'(1)) begin
          k <= k + TERMS_WIDTH'(1);
        end
      end
      ST_ACC: begin
        acc <= acc_c.val;
        sat <= sat | q_r.ovf | acc_c.ovf;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_room) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_room) begin
      m_tdata <= acc;
      m_tuser <= sat;
    end
  end

  // checks
  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_tuser == CMD_EVAL && !enable) |=>
      (state == ST_OUT && acc == '0 && !sat))
    else $error("disabled evaluate must give zero");

  a_term_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_D || state == ST_W) |-> (k < terms))
    else $error("term counter beyond term count");

  a_addr_track: assert property (@(posedge clk) disable iff (rst)
    (state == ST_D) |-> (rd_addr == AW'(k + TERMS_WIDTH'(1))))
    else $error("table read address out of step with term");

  a_hold_output: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (state != ST_IDLE || !$past(state == ST_OUT)))
    else $error("result left the sequencer while output was full");

endmodule

`default_nettype wire

### hdl/opnc_ram.sv
// ----------------------------------------------------------------------------
// opnc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module opnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
